### hw/rtl/nawm_pkg.sv
package nawm_pkg;

  // pattern character codes, one nibble each
  localparam logic [3:0] CODE_STAR  = 4'd10;
  localparam logic [3:0] CODE_QMARK = 4'd11;
  localparam logic [3:0] CODE_END   = 4'd15;

  // default number of pattern characters per part
  localparam int PATTERN_CHARS_DEF = 9;

  // decimal digits of a 16-bit number
  localparam int DIGITS = 5;
  localparam int BCD_W  = 4 * DIGITS;

  // address parts
  localparam int PARTS  = 4;
  localparam int PART_W = 16;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // register indexes
  typedef enum logic [1:0] {
    REG_ZONE  = 2'd0,
    REG_NET   = 2'd1,
    REG_NODE  = 2'd2,
    REG_POINT = 2'd3
  } reg_idx_t;

  // input and output stream widths
  localparam int S_DATA_W = PARTS * PART_W;
  localparam int M_DATA_W = 8;

endpackage

### hw/rtl/node_address_wildcard_match_core.sv
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------------
// s_axis    | in        | s_tvalid/s_tready  | s_tdata: zone, net, node, point (16 each)
// m_axis    | out       | m_tvalid/m_tready  | m_tdata: is_match (bit 0)
// apb cfg   | in        | psel/penable/pready| four 4*PATTERN_CHARS-bit pattern registers
//
// one address per cycle sustained while m_tready is high; each address goes from input
// transaction to result through two double-dabble stages of 8 bits each, one stage
// that classifies every pattern character, and one that resolves the first
// stopping character into the result register.
// rst is synchronous and clears the stage valid bits and sets every pattern to '*'.
// a stall on m_tready holds each full stage; a stage accepts when it is empty
// or the stage after it moves, so no address is lost or repeated.
module node_address_wildcard_match_core #(
  parameter int PATTERN_CHARS = nawm_pkg::PATTERN_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input address stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // fields from bit 0: addr_zone, addr_net, addr_node, addr_point
  input  logic [nawm_pkg::S_DATA_W-1:0]   s_tdata,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // fields from bit 0: is_match, then zero fill
  output logic [nawm_pkg::M_DATA_W-1:0]   m_tdata,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nawm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nawm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nawm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int PAT_W  = 4 * PATTERN_CHARS;
  localparam int PARTS  = nawm_pkg::PARTS;
  localparam int PART_W = nawm_pkg::PART_W;
  localparam int BCD_W  = nawm_pkg::BCD_W;
  localparam int DIGITS = nawm_pkg::DIGITS;
  localparam int HALF_W = PART_W / 2;

  // eight shift-and-correct steps of double dabble
  function automatic logic [BCD_W-1:0] dd_half(input logic [BCD_W-1:0] bcd_in,
                                               input logic [HALF_W-1:0] bits);
    logic [BCD_W-1:0] b;
    b = bcd_in;
    for (int i = 0; i < HALF_W; i++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[4*d +: 4] >= 4'd5) b[4*d +: 4] = b[4*d +: 4] + 4'd3;
      end
      b = {b[BCD_W-2:0], bits[HALF_W-1-i]};
    end
    return b;
  endfunction

  // number of decimal digits without leading zeros, at least one
  function automatic logic [2:0] digit_len(input logic [BCD_W-1:0] bcd);
    logic [2:0] n;
    n = 3'd1;
    for (int d = 1; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) n = 3'(d + 1);
    end
    return n;
  endfunction

  // every nibble is a decimal digit
  function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

  // pattern registers
  logic [PAT_W-1:0] pat [PARTS];
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  // pipeline registers
  logic              s1_v, s2_v, s3_v;
  logic [BCD_W-1:0]  s1_bcd [PARTS];
  logic [HALF_W-1:0] s1_lo  [PARTS];
  logic [BCD_W-1:0]  s2_bcd [PARTS];
  logic [PATTERN_CHARS-1:0] s3_stop [PARTS];
  logic [PATTERN_CHARS-1:0] s3_verd [PARTS];
  logic [PARTS-1:0]  s3_dflt;
  logic              s3_zskip;
  logic              s4_match;

  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // stage 3 classification and stage 4 resolution
  logic [PATTERN_CHARS-1:0] stop_next [PARTS];
  logic [PATTERN_CHARS-1:0] verd_next [PARTS];
  logic [PARTS-1:0]         dflt_next;
  logic [PARTS-1:0]         part_ok;
  logic                     match_next;

  // apb write decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PARTS; p++) begin
        pat[p] <= {{(PAT_W-4){1'b1}}, nawm_pkg::CODE_STAR};
      end
    end else if (cfg_wr) begin
      unique case (nawm_pkg::reg_idx_t'(cfg_idx))
        nawm_pkg::REG_ZONE:  pat[nawm_pkg::REG_ZONE]  <= pwdata[PAT_W-1:0];
        nawm_pkg::REG_NET:   pat[nawm_pkg::REG_NET]   <= pwdata[PAT_W-1:0];
        nawm_pkg::REG_NODE:  pat[nawm_pkg::REG_NODE]  <= pwdata[PAT_W-1:0];
        nawm_pkg::REG_POINT: pat[nawm_pkg::REG_POINT] <= pwdata[PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // apb read data
  assign prdata = nawm_pkg::CFG_DATA_W'(pat[cfg_idx]);

  // stage handshake chain
  assign s4_ready = !m_tvalid || m_tready;
  assign s3_ready = !s3_v || s4_ready;
  assign s2_ready = !s2_v || s3_ready;
  assign s1_ready = !s1_v || s2_ready;
  assign s_tready = s1_ready;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_ready) s1_v     <= s_tvalid;
      if (s2_ready) s2_v     <= s1_v;
      if (s3_ready) s3_v     <= s2_v;
      if (s4_ready) m_tvalid <= s3_v;
    end
  end

  // stage 1: high byte of each number into bcd
  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      for (int p = 0; p < PARTS; p++) begin
        s1_bcd[p] <= dd_half('0, s_tdata[p*PART_W + HALF_W +: HALF_W]);
        s1_lo[p]  <= s_tdata[p*PART_W +: HALF_W];
      end
    end
  end

  // stage 2: low byte of each number into bcd
  always_ff @(posedge clk) begin
    if (s2_ready && s1_v) begin
      for (int p = 0; p < PARTS; p++) begin
        s2_bcd[p] <= dd_half(s1_bcd[p], s1_lo[p]);
      end
    end
  end

  // stage 3: per character, does the scan stop here and with what verdict
  always_comb begin
    logic [2:0] len;
    logic [3:0] ch;
    logic [3:0] dig;
    logic [2:0] idx;
    for (int p = 0; p < PARTS; p++) begin
      len = digit_len(s2_bcd[p]);
      dflt_next[p] = (PATTERN_CHARS >= int'(len));
      for (int c = 0; c < PATTERN_CHARS; c++) begin
        ch  = pat[p][4*c +: 4];
        dig = 4'd0;
        idx = 3'd0;
        if (c < int'(len)) begin
          idx = 3'(int'(len) - 1 - c);
          dig = s2_bcd[p][4*idx +: 4];
        end
        if (ch == nawm_pkg::CODE_END) begin
          stop_next[p][c] = 1'b1;
          verd_next[p][c] = (c == 0) || (c >= int'(len));
        end else if (ch == nawm_pkg::CODE_STAR) begin
          stop_next[p][c] = 1'b1;
          verd_next[p][c] = 1'b1;
        end else if ((c >= int'(len)) || ((ch != nawm_pkg::CODE_QMARK) && (ch != dig))) begin
          stop_next[p][c] = 1'b1;
          verd_next[p][c] = 1'b0;
        end else begin
          stop_next[p][c] = 1'b0;
          verd_next[p][c] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_v) begin
      for (int p = 0; p < PARTS; p++) begin
        s3_stop[p] <= stop_next[p];
        s3_verd[p] <= verd_next[p];
      end
      s3_dflt  <= dflt_next;
      s3_zskip <= (s2_bcd[nawm_pkg::REG_ZONE] == '0);
    end
  end

  // stage 4: first stopping character decides each part
  always_comb begin
    for (int p = 0; p < PARTS; p++) begin
      part_ok[p] = s3_dflt[p];
      for (int c = PATTERN_CHARS - 1; c >= 0; c--) begin
        if (s3_stop[p][c]) part_ok[p] = s3_verd[p][c];
      end
    end
    match_next = (s3_zskip || part_ok[nawm_pkg::REG_ZONE]) && part_ok[nawm_pkg::REG_NET]
                 && part_ok[nawm_pkg::REG_NODE] && part_ok[nawm_pkg::REG_POINT];
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_v) s4_match <= match_next;
  end

  assign m_tdata = {{(nawm_pkg::M_DATA_W-1){1'b0}}, s4_match};

  // checks
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> s1_v)
    else $error("accepted address did not reach stage 1");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the result stage is empty");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> bcd_ok(s2_bcd[0]) && bcd_ok(s2_bcd[1]) && bcd_ok(s2_bcd[2]) && bcd_ok(s2_bcd[3]))
    else $error("bcd conversion produced a nibble above nine");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_v && !s3_ready |=> s2_v && $stable(s2_bcd[1]))
    else $error("stalled stage 2 lost its contents");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int PAT_CHARS = nawm_pkg::PATTERN_CHARS_DEF;
  localparam int PAT_W = 4 * PAT_CHARS;
  localparam logic [PAT_W-1:0] PAT_RESET =
    {{(PAT_CHARS-1){nawm_pkg::CODE_END}}, nawm_pkg::CODE_STAR};

  localparam int PART_W     = nawm_pkg::PART_W;
  localparam int PARTS      = nawm_pkg::PARTS;
  localparam int DIGITS     = nawm_pkg::DIGITS;
  localparam int S_DATA_W   = nawm_pkg::S_DATA_W;
  localparam int M_DATA_W   = nawm_pkg::M_DATA_W;
  localparam int CFG_ADDR_W = nawm_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = nawm_pkg::CFG_DATA_W;

  // codes that equal no digit
  localparam logic [3:0] CODE_NONE_LO = 4'd12;
  localparam logic [3:0] CODE_NONE_MID = 4'd13;
  localparam logic [3:0] CODE_NONE_HI = 4'd14;

  localparam int IDLE_PCT = 38;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 95;

  // one address, zone in the lowest bits as on s_tdata
  typedef struct packed {
    logic [PART_W-1:0] point;
    logic [PART_W-1:0] node;
    logic [PART_W-1:0] net;
    logic [PART_W-1:0] zone;
  } addr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // fields from bit 0: addr_zone, addr_net, addr_node, addr_point
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // fields from bit 0: is_match, then zero fill
  logic [M_DATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // shadow copy of the pattern registers
  logic [PAT_W-1:0] pat_reg [PARTS] = '{default: PAT_RESET};

  addr_t addr_q[$];
  bit match_q[$];

  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int errors = 0;
  int addrs_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int settings = 0;
  int quiet_cycles = 0;

  node_address_wildcard_match_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // one part against its pattern, digits without leading zeros
  function automatic bit part_hit(logic [PAT_W-1:0] pat, logic [PART_W-1:0] num);
    int unsigned rev [DIGITS];
    int unsigned dig [DIGITS];
    int unsigned v;
    int len;
    int c;
    logic [3:0] ch;
    v = num;
    len = 0;
    do begin
      rev[len] = v % 10;
      v = v / 10;
      len++;
    end while (v != 0);
    for (c = 0; c < len; c++) dig[c] = rev[len-1-c];
    if (pat[3:0] == nawm_pkg::CODE_END) return 1'b1;
    for (c = 0; c < PAT_CHARS; c++) begin
      ch = pat[4*c +: 4];
      if (ch == nawm_pkg::CODE_END) break;
      if (ch == nawm_pkg::CODE_STAR) return 1'b1;
      if (c >= len) return 1'b0;
      if (ch == nawm_pkg::CODE_QMARK) continue;
      if (32'(ch) != dig[c]) return 1'b0;
    end
    return c >= len;
  endfunction

  function automatic bit address_matches(addr_t a);
    return (a.zone == '0 || part_hit(pat_reg[nawm_pkg::REG_ZONE], a.zone)) &&
           part_hit(pat_reg[nawm_pkg::REG_NET], a.net) &&
           part_hit(pat_reg[nawm_pkg::REG_NODE], a.node) &&
           part_hit(pat_reg[nawm_pkg::REG_POINT], a.point);
  endfunction

  // pattern text to register value: digits, '*', '?', x/y/z for the codes 12..14
  function automatic logic [CFG_DATA_W-1:0] pat_of(string s);
    logic [CFG_DATA_W-1:0] v;
    logic [3:0] ch;
    v = '0;
    for (int i = 0; i < PAT_CHARS; i++) begin
      if (i >= s.len()) ch = nawm_pkg::CODE_END;
      else if (s[i] == "*") ch = nawm_pkg::CODE_STAR;
      else if (s[i] == "?") ch = nawm_pkg::CODE_QMARK;
      else if (s[i] == "x") ch = CODE_NONE_LO;
      else if (s[i] == "y") ch = CODE_NONE_MID;
      else if (s[i] == "z") ch = CODE_NONE_HI;
      else ch = 4'(s[i] - "0");
      v[4*i +: 4] = ch;
    end
    return v;
  endfunction

  // random pattern; nibbles after the end and bits above the pattern are noise
  function automatic logic [CFG_DATA_W-1:0] rand_pattern();
    logic [CFG_DATA_W-1:0] v;
    int len;
    int r;
    v = {$urandom, $urandom};
    len = ($urandom_range(0, 9) == 0) ? PAT_CHARS : $urandom_range(0, 6);
    for (int i = 0; i < PAT_CHARS; i++) begin
      r = $urandom_range(0, 99);
      if (i == len) v[4*i +: 4] = nawm_pkg::CODE_END;
      else if (i > len) v[4*i +: 4] = 4'($urandom);
      else if (r < 60) v[4*i +: 4] = 4'($urandom_range(0, 9));
      else if (r < 72) v[4*i +: 4] = nawm_pkg::CODE_STAR;
      else if (r < 96) v[4*i +: 4] = nawm_pkg::CODE_QMARK;
      else v[4*i +: 4] = 4'($urandom_range(12, 14));
    end
    return v;
  endfunction

  function automatic logic [PART_W-1:0] rand_num();
    case ($urandom_range(0, 9)) inside
      0: return '0;
      1: return '1;
      [2:3]: return PART_W'($urandom_range(0, 9));
      [4:5]: return PART_W'($urandom_range(10, 999));
      default: return PART_W'($urandom);
    endcase
  endfunction

  // a number spelled out from the pattern, now and then bent by one digit
  function automatic logic [PART_W-1:0] num_near(logic [PAT_W-1:0] pat);
    longint unsigned v;
    int n;
    logic [3:0] ch;
    v = 0;
    n = 0;
    for (int i = 0; i < PAT_CHARS; i++) begin
      ch = pat[4*i +: 4];
      if (ch == nawm_pkg::CODE_END) break;
      if (ch == nawm_pkg::CODE_STAR) begin
        repeat ($urandom_range(0, 2)) begin
          v = v * 10 + $urandom_range(0, 9);
          n++;
        end
        break;
      end
      v = v * 10 + ((ch < 4'd10) ? ch : $urandom_range(0, 9));
      n++;
      if (n > DIGITS) break;
    end
    case ($urandom_range(0, 11))
      0: v = v * 10 + $urandom_range(0, 9);
      1: v = v / 10;
      default: ;
    endcase
    if (n > DIGITS || v > 65535) return rand_num();
    return PART_W'(v);
  endfunction

  task automatic push_addr(int z, int n, int d, int p);
    addr_t a;
    a.zone = PART_W'(z);
    a.net = PART_W'(n);
    a.node = PART_W'(d);
    a.point = PART_W'(p);
    addr_q.push_back(a);
  endtask

  task automatic apb_write(nawm_pkg::reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pat_reg[idx] = val[PAT_W-1:0];
  endtask

  task automatic load_patterns(logic [CFG_DATA_W-1:0] z, logic [CFG_DATA_W-1:0] n,
                               logic [CFG_DATA_W-1:0] d, logic [CFG_DATA_W-1:0] p);
    apb_write(nawm_pkg::REG_ZONE, z);
    apb_write(nawm_pkg::REG_NET, n);
    apb_write(nawm_pkg::REG_NODE, d);
    apb_write(nawm_pkg::REG_POINT, p);
    settings++;
  endtask

  // hold off until every address is out and checked, then let the pipe settle
  task automatic drain();
    do @(negedge clk); while (addr_q.size() != 0 || match_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // address driver
  always @(posedge clk) begin : drive_proc
    addr_t a;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        a = addr_q.pop_front();
        match_q.push_back(address_matches(a));
        addrs_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (addr_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata <= addr_q[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : watch_proc
    bit want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (match_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result %0d arrived with none outstanding", results_seen);
        end else begin
          want = match_q.pop_front();
          if (want) hits_seen++;
          if (m_tdata[0] !== want) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: is_match expected %0b got %0b",
                       results_seen, want, m_tdata[0]);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (hold_done < hold_req) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= hold_done + 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // watchdog on cycles without any stream transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [CFG_DATA_W-1:0] z, n, d, p;
    addr_t a;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset patterns are '*' everywhere
    push_addr(0, 0, 0, 0);
    push_addr(65535, 65535, 65535, 65535);
    push_addr(1, 10, 100, 1000);
    drain();

    // exact digit, '?' past the digits, star tail, empty pattern
    load_patterns(pat_of("2"), pat_of("5?"), pat_of("1*"), pat_of(""));
    push_addr(0, 57, 1, 9);
    push_addr(3, 57, 1, 9);
    push_addr(2, 5, 1, 9);
    push_addr(2, 570, 19999, 65535);
    push_addr(2, 57, 2, 0);
    push_addr(2, 50, 10, 0);
    drain();

    // digit past the digits, unreached bad code, pattern without end code
    load_patterns(pat_of("12"), pat_of("?*x"), pat_of("6553?****"), pat_of("0"));
    push_addr(12, 7, 65535, 0);
    push_addr(1, 7, 65535, 0);
    push_addr(12, 123, 65534, 0);
    push_addr(12, 7, 6553, 0);
    push_addr(12, 7, 65535, 10);
    push_addr(0, 7, 65535, 0);
    drain();

    // codes that equal no digit
    load_patterns(pat_of("z"), pat_of("1x"), pat_of("y*"), pat_of("??"));
    push_addr(0, 1, 4, 99);
    push_addr(5, 15, 4, 99);
    push_addr(0, 1, 40, 9);
    push_addr(0, 12, 0, 10);
    drain();

    // random phases: all-zero and all-one registers first, then random patterns
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) load_patterns('0, '0, '0, '0);
      else if (ph == 1) load_patterns('1, '1, '1, '1);
      else load_patterns(rand_pattern(), rand_pattern(), rand_pattern(), rand_pattern());
      no_idle = (ph == 4);
      if (ph == 6) hold_req++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        a.zone = ($urandom_range(0, 6) == 0) ? '0 :
                 ($urandom_range(0, 9) < 7) ? num_near(pat_reg[nawm_pkg::REG_ZONE]) :
                 rand_num();
        a.net = ($urandom_range(0, 9) < 7) ? num_near(pat_reg[nawm_pkg::REG_NET]) :
                rand_num();
        a.node = ($urandom_range(0, 9) < 7) ? num_near(pat_reg[nawm_pkg::REG_NODE]) :
                 rand_num();
        a.point = ($urandom_range(0, 9) < 7) ? num_near(pat_reg[nawm_pkg::REG_POINT]) :
                  rand_num();
        addr_q.push_back(a);
      end
      drain();
      no_idle = 1'b0;
    end

    errors += match_q.size();
    $display("checked %0d results for %0d addresses under %0d pattern settings",
             results_seen, addrs_sent, settings);
    $display("%0d addresses matched, %0d did not", hits_seen, results_seen - hits_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
